// ----- hw/rtl/swts_pkg.sv -----
package swts_pkg;

  // time width, fixed by the time fields of both beats
  localparam int TIME_W = 48;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam int CH_FIELD_W  = 5;
  localparam int LEN_W       = 20;
  localparam int IDX_FIELD_W = 4;
  localparam int CFG_W       = 16;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  // register select, taken from paddr[2]
  localparam logic REG_GUARD    = 1'b0;
  localparam logic REG_OVERHEAD = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0]     now_ticks;
    logic [CH_FIELD_W-1:0] channel;
    logic                  is_grant;
    logic [LEN_W-1:0]      frame_bits;
    logic [LEN_W-1:0]      round_trip_ticks;
  } swts_in_t;

  typedef struct packed {
    logic [TIME_W-1:0]      tx_time;
    logic [IDX_FIELD_W-1:0] tx_index;
    logic [IDX_FIELD_W-1:0] rx_index;
  } swts_out_t;

  // saturating add of two times
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] max_time(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ----- hw/rtl/sequential_wdm_tx_scheduler_unit.sv -----
// transmit scheduler for a wdm passive optical network, one frame per request
//
// input channel: in_valid / in_stall / in_data; one beat is one frame request
// (current time, channel, grant flag, frame length, round-trip time).
// result channel: out_valid / out_stall / out_data; one beat per request
// with the start time, the transmitter index and, for grants, the receiver.
// config: apb-style port, pready tied high, guard interval at byte 0, grant
// overhead at byte 4; the user writes it only while the block is idle, unenforced.
//
// timing: after acceptance a request passes the load state, the transmitter
// scan, for grants the receiver scan, then the transmitter, channel and, for
// grants, receiver term states, the end state and the write state. the
// free time scan runs serially through one comparator. in_stall is high from
// acceptance until the result is loaded, so no new beat is taken meanwhile.
// the result sits in an output register: a stalled result does not block
// the next request, only the loading of the one after it.
// reset: all free times read as zero (valid bits on the channel memory), the
// configuration registers and the scan counter clear to zero, no result pending.
module sequential_wdm_tx_scheduler_unit
  import swts_pkg::*;
#(
  parameter int NUM_CHANNELS = 32,
  parameter int NUM_TX       = 4,
  parameter int NUM_RX       = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  swts_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output swts_out_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CHW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int TXW  = (NUM_TX > 1) ? $clog2(NUM_TX) : 1;
  localparam int RXW  = (NUM_RX > 1) ? $clog2(NUM_RX) : 1;
  localparam int CNTW = (TXW > RXW) ? TXW : RXW;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_SCAN_TX, S_SCAN_RX, S_TX_TERM,
    S_CH_TERM, S_RX_TERM, S_END, S_WRITE
  } state_t;

  state_t state_r;

  // configuration registers
  logic [CFG_W-1:0] guard_r;
  logic [CFG_W-1:0] overhead_r;

  // latched request
  swts_in_t         req_r;
  logic             ch_ok_r;
  logic [CHW-1:0]   ch_idx;

  // running maximum of every current time seen; every stored free time is
  // read as no earlier than this
  logic [TIME_W-1:0] now_max_r;

  // free time stores
  logic [TIME_W-1:0] ch_mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] ch_vld_r;
  logic [TIME_W-1:0] ch_rd_r;
  logic              ch_rd_vld_r;
  logic [TIME_W-1:0] tx_free_r [NUM_TX];
  logic [TIME_W-1:0] rx_free_r [NUM_RX];

  // scan and datapath registers
  logic [CNTW-1:0]   cnt_r;
  logic [TIME_W-1:0] tx_best_r;
  logic [TXW-1:0]    tx_idx_r;
  logic [TIME_W-1:0] rx_best_r;
  logic [RXW-1:0]    rx_idx_r;
  logic [TIME_W-1:0] t_r;
  logic [TIME_W-1:0] end_r;

  logic      out_valid_r;
  swts_out_t out_data_r;

  // ---------------------------------------------------------------------
  // apb configuration port
  // ---------------------------------------------------------------------
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      REG_GUARD:    prdata = {{(APB_DATA_W-CFG_W){1'b0}}, guard_r};
      REG_OVERHEAD: prdata = {{(APB_DATA_W-CFG_W){1'b0}}, overhead_r};
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // request decode
  // ---------------------------------------------------------------------
  logic          in_acc;
  logic [7:0]    ch_ext;
  logic [8:0]    num_ch_w;
  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign ch_ext   = {{(8-CH_FIELD_W){1'b0}}, req_r.channel};
  assign num_ch_w = 9'(NUM_CHANNELS);

  // ---------------------------------------------------------------------
  // shared scan comparator: picks the earliest free time, ties go to the
  // later index
  // ---------------------------------------------------------------------
  logic              scan_rx;
  logic [TIME_W-1:0] cand_raw;
  logic [TIME_W-1:0] cand;
  logic [TIME_W-1:0] best_cur;
  logic              take;
  logic              scan_last;

  assign scan_rx = (state_r == S_SCAN_RX);

  always_comb begin
    cand_raw  = scan_rx ? rx_free_r[cnt_r[RXW-1:0]] : tx_free_r[cnt_r[TXW-1:0]];
    cand      = max_time(cand_raw, now_max_r);
    best_cur  = scan_rx ? rx_best_r : tx_best_r;
    take      = (cnt_r == '0) || (cand <= best_cur);
    scan_last = scan_rx ? (cnt_r == CNTW'(NUM_RX - 1)) : (cnt_r == CNTW'(NUM_TX - 1));
  end

  // ---------------------------------------------------------------------
  // term arithmetic
  // ---------------------------------------------------------------------
  logic [TIME_W-1:0]   guard_t;
  logic [TIME_W-1:0]   ch_base;
  logic [TIME_W-1:0]   ch_term;
  logic [LEN_W:0]      rx_sub;
  logic signed [TIME_W+1:0] rx_diff;
  logic [TIME_W-1:0]   rx_term;
  logic                out_free;
  logic                ch_wr;

  always_comb begin
    guard_t = {{(TIME_W-CFG_W){1'b0}}, guard_r};
    ch_base = ch_ok_r ? max_time(ch_rd_vld_r ? ch_rd_r : '0, now_max_r) : req_r.now_ticks;
    ch_term = sat_add(ch_base, guard_t);
    // r + guard - (rtt + overhead), clamped to zero below and to the maximum above
    rx_sub  = {1'b0, req_r.round_trip_ticks} + (LEN_W+1)'(overhead_r);
    rx_diff = $signed({2'b00, rx_best_r}) + $signed({{(TIME_W-CFG_W+2){1'b0}}, guard_r})
            - $signed({{(TIME_W-LEN_W+1){1'b0}}, rx_sub});
    if (rx_diff[TIME_W+1]) begin
      rx_term = '0;
    end else if (rx_diff[TIME_W]) begin
      rx_term = TIME_MAX;
    end else begin
      rx_term = rx_diff[TIME_W-1:0];
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign ch_wr    = (state_r == S_WRITE) && out_free && ch_ok_r;

  // ---------------------------------------------------------------------
  // channel free time memory
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (ch_wr) begin
      ch_mem[ch_idx] <= end_r;
    end
    if (state_r == S_LOAD) begin
      ch_rd_r <= ch_mem[ch_idx];
    end
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      guard_r     <= '0;
      overhead_r  <= '0;
      now_max_r   <= '0;
      ch_vld_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_TX; i++) tx_free_r[i] <= '0;
      for (int i = 0; i < NUM_RX; i++) rx_free_r[i] <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[2])
          REG_GUARD:    guard_r    <= pwdata[CFG_W-1:0];
          REG_OVERHEAD: overhead_r <= pwdata[CFG_W-1:0];
          default:      ;
        endcase
      end

      // a result taken while the next one loads is replaced in the write state
      if (out_valid_r && !out_stall && (state_r != S_WRITE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            req_r   <= in_data;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          ch_ok_r     <= {1'b0, ch_ext} < num_ch_w;
          ch_rd_vld_r <= ch_vld_r[ch_idx];
          now_max_r   <= max_time(now_max_r, req_r.now_ticks);
          cnt_r       <= '0;
          state_r     <= S_SCAN_TX;
        end
        S_SCAN_TX: begin
          if (take) begin
            tx_best_r <= cand;
            tx_idx_r  <= cnt_r[TXW-1:0];
          end
          if (scan_last) begin
            cnt_r   <= '0;
            state_r <= req_r.is_grant ? S_SCAN_RX : S_TX_TERM;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_SCAN_RX: begin
          if (take) begin
            rx_best_r <= cand;
            rx_idx_r  <= cnt_r[RXW-1:0];
          end
          if (scan_last) begin
            cnt_r   <= '0;
            state_r <= S_TX_TERM;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_TX_TERM: begin
          t_r     <= sat_add(tx_best_r, guard_t);
          state_r <= S_CH_TERM;
        end
        S_CH_TERM: begin
          t_r     <= max_time(t_r, ch_term);
          state_r <= req_r.is_grant ? S_RX_TERM : S_END;
        end
        S_RX_TERM: begin
          t_r     <= max_time(t_r, rx_term);
          state_r <= S_END;
        end
        S_END: begin
          end_r   <= sat_add(t_r, {{(TIME_W-LEN_W){1'b0}}, req_r.frame_bits});
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          // hold here while an earlier result still waits downstream
          if (out_free) begin
            if (ch_ok_r) begin
              ch_vld_r[ch_idx] <= 1'b1;
            end
            tx_free_r[tx_idx_r] <= end_r;
            if (req_r.is_grant) begin
              rx_free_r[rx_idx_r] <=
                sat_add(end_r, {{(TIME_W-LEN_W){1'b0}}, req_r.round_trip_ticks});
            end
            out_data_r.tx_time  <= t_r;
            out_data_r.tx_index <= IDX_FIELD_W'(tx_idx_r);
            out_data_r.rx_index <= req_r.is_grant ? IDX_FIELD_W'(rx_idx_r) : '0;
            out_valid_r         <= 1'b1;
            state_r             <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // channel memory address follows the latched request
  always_comb begin
    ch_idx = ch_ext[CHW-1:0];
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_tx_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_data.tx_index} < (IDX_FIELD_W+1)'(NUM_TX)))
    else $error("transmitter index out of range");

  a_rx_idx_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE && out_free && !req_r.is_grant) |=> (out_data.rx_index == '0))
    else $error("receiver index not zero for a data frame");

  a_start_not_early: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> (t_r >= req_r.now_ticks))
    else $error("start time before current time");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (in_stall && !$rose(out_valid)))
    else $error("request accepted without a busy period");

endmodule
